// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// Each expands to one concurrent assertion clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcv_pkg.sv -----
// Package for the tanh transfer curve: widths, register codes, reset values, tanh table.
// No dependencies; used by the interfaces and the top level.
package tcv_pkg;

    // Table size and derived index widths
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TIX_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int TAB_W  = 15;              // table values 0..16384
    localparam int FRAC_W = 26;              // |u| < 4.0 in Q24
    localparam int S_W    = FRAC_W + IDX_W;
    localparam int DIFF_W = TAB_W + 1;
    localparam int IP_W   = DIFF_W + FRAC_W;
    localparam int OUT_SH = 16;              // gain is Q8.16

    // Sample and register widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // Pipeline depth (last stage is the output register)
    localparam int NSTG = 10;
    localparam int LAST = NSTG - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 2'd3;

    // Reset values
    localparam logic [15:0]        SLOPE_RST  = 16'd3986;
    localparam logic signed [15:0] CENTRE_RST = 16'sh2000;
    localparam logic [23:0]        GAIN_RST   = 24'h010000;
    localparam logic signed [15:0] FLOOR_RST  = 16'shC000;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef logic [TAB_W-1:0] tanh_tab_t [0:TABLE_ENTRIES];

    // Unsigned restoring long division, used only while building the table
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(4i/N) in Q14: e^(i/N) by truncated Taylor series in Q30,
    // reciprocal, squared three times, then (1-E)/(1+E) rounded.
    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t   tab;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] iv;
        logic [63:0] k;
        n = 64'(TABLE_ENTRIES);
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            iv   = 64'(i);
            term = Q30_ONE;
            sum  = Q30_ONE;
            k    = 64'd1;
            while (k < 64'd40 && term != 64'd0)
            begin
                term = div_u64(term * iv, n * k);
                sum  = sum + term;
                k    = k + 64'd1;
            end
            e = div_u64((Q30_ONE << 30) + (sum >> 1), sum);
            for (int r = 0; r < 3; r++)
            begin
                e = (e * e + (Q30_ONE >> 1)) >> 30;
            end
            tab[i] = TAB_W'(div_u64(((Q30_ONE - e) << 14) + ((Q30_ONE + e) >> 1),
                                    Q30_ONE + e));
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// ----- design/tcv_sample_if.sv -----
// Input sample channel: valid/ready handshake carrying one Q2.14 sample.
// Depends on tcv_pkg.
interface tcv_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tcv_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- design/tcv_result_if.sv -----
// Result channel: valid/ready handshake carrying the shaped sample and clip flag.
// Depends on tcv_pkg.
interface tcv_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tcv_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- design/tcv_cfg_if.sv -----
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on tcv_pkg.
interface tcv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tcv_pkg::CFG_IDX_W-1:0]      index;
    logic [tcv_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/tanh_transfer_curve_top.sv -----
// Normalised tanh transfer curve: y = gain * (tanh(slope * (x - centre)) - floor_value),
// saturated to Q2.14 with a clip flag. One sample is accepted per clock while the
// output is not held; each result passes through the ten register stages of the
// datapath (subtract, slope multiply, magnitude, table address, table read, interpolation
// multiply, interpolation add, floor subtract, gain multiply, round and clamp). Each stage
// holds its item while the stage after it is full and not loading, so an empty stage
// keeps taking new requests while a finished result waits at the output. Configuration
// writes are always taken and should be made with no sample in flight.
// Depends on tcv_pkg, tcv_sample_if, tcv_result_if, tcv_cfg_if and assert_macros.svh.
`include "assert_macros.svh"

module tanh_transfer_curve_top
(
    input  logic                clk,
    input  logic                rst_n,
    tcv_sample_if.sink          samples,
    tcv_result_if.source        results,
    tcv_cfg_if.sink             cfg
);

    // Configuration registers
    logic [15:0]                      slope_reg;
    logic signed [15:0]               centre_reg;
    logic [23:0]                      gain_reg;
    logic signed [15:0]               floor_reg;

    // Stage valid bits and load enables
    logic [tcv_pkg::NSTG-1:0]         vld_reg;
    logic [tcv_pkg::NSTG-1:0]         en;

    // Stage payloads
    logic signed [16:0]               d_reg;
    logic signed [32:0]               u_reg;
    logic [tcv_pkg::FRAC_W-1:0]       mag_reg;
    logic                             sat3_reg;
    logic                             neg3_reg;
    logic [tcv_pkg::IDX_W-1:0]        idx_reg;
    logic [tcv_pkg::FRAC_W-1:0]       frac4_reg;
    logic                             sat4_reg;
    logic                             neg4_reg;
    logic [tcv_pkg::TAB_W-1:0]        lo5_reg;
    logic signed [tcv_pkg::DIFF_W-1:0] diff_reg;
    logic [tcv_pkg::FRAC_W-1:0]       frac5_reg;
    logic                             sat5_reg;
    logic                             neg5_reg;
    logic [tcv_pkg::TAB_W-1:0]        lo6_reg;
    logic signed [tcv_pkg::IP_W-1:0]  ip_reg;
    logic                             sat6_reg;
    logic                             neg6_reg;
    logic [tcv_pkg::TAB_W-1:0]        tmag_reg;
    logic                             neg7_reg;
    logic signed [16:0]               w_reg;
    logic signed [40:0]               p_reg;
    logic signed [15:0]               y_reg;
    logic                             clip_reg;

    // Combinational next values
    logic signed [16:0]               d_next;
    logic signed [16:0]               slope_ext;
    logic signed [33:0]               u_full;
    logic [32:0]                      mag_abs;
    logic [tcv_pkg::S_W-1:0]          s_full;
    logic [tcv_pkg::TIX_W-1:0]        idx_ext;
    logic [tcv_pkg::TIX_W-1:0]        idx_p1;
    logic [tcv_pkg::TAB_W-1:0]        lo_next;
    logic [tcv_pkg::TAB_W-1:0]        hi_next;
    logic signed [tcv_pkg::DIFF_W-1:0] diff_next;
    logic signed [tcv_pkg::FRAC_W:0]  frac_ext;
    logic signed [tcv_pkg::IP_W:0]    ip_full;
    logic [tcv_pkg::IP_W-1:0]         ip_abs;
    logic [tcv_pkg::IP_W-1:0]         ip_sh;
    logic signed [16:0]               interp;
    logic signed [16:0]               tsum;
    logic [tcv_pkg::TAB_W-1:0]        tmag_next;
    logic signed [15:0]               t_sgn;
    logic signed [16:0]               w_next;
    logic signed [24:0]               gain_ext;
    logic signed [41:0]               p_full;
    logic [40:0]                      p_abs;
    logic [40:0]                      q_full;
    logic [24:0]                      q;
    logic signed [15:0]               y_next;
    logic                             clip_next;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg  <= tcv_pkg::SLOPE_RST;
            centre_reg <= tcv_pkg::CENTRE_RST;
            gain_reg   <= tcv_pkg::GAIN_RST;
            floor_reg  <= tcv_pkg::FLOOR_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tcv_pkg::REG_SLOPE:  slope_reg  <= cfg.data[15:0];
                tcv_pkg::REG_CENTRE: centre_reg <= cfg.data[15:0];
                tcv_pkg::REG_GAIN:   gain_reg   <= cfg.data;
                tcv_pkg::REG_FLOOR:  floor_reg  <= cfg.data[15:0];
                default:             ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[tcv_pkg::LAST] = !vld_reg[tcv_pkg::LAST] || results.ready;
        for (int k = tcv_pkg::LAST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    assign samples.ready = en[0];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= samples.valid;
            end
            for (int k = 1; k < tcv_pkg::NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // Stage 1: d = x - centre
    assign d_next = $signed({samples.sample_in[15], samples.sample_in})
                  - $signed({centre_reg[15], centre_reg});

    // Stage 2: u = slope * d (Q24)
    assign slope_ext = $signed({1'b0, slope_reg});
    assign u_full    = slope_ext * d_reg;

    // Stage 3: magnitude and saturation test against 4.0
    assign mag_abs = u_reg[32] ? (33'd0 - u_reg) : u_reg;

    // Stage 4: table position = |u| * entries
    assign s_full = tcv_pkg::S_W'(mag_reg) * tcv_pkg::S_W'(tcv_pkg::TABLE_ENTRIES);

    // Stage 5: neighbouring table points
    assign idx_ext   = tcv_pkg::TIX_W'(idx_reg);
    assign idx_p1    = idx_ext + tcv_pkg::TIX_W'(1);
    assign lo_next   = tcv_pkg::TANH_TAB[idx_ext];
    assign hi_next   = tcv_pkg::TANH_TAB[idx_p1];
    assign diff_next = $signed({1'b0, hi_next}) - $signed({1'b0, lo_next});

    // Stage 6: slope between points times fraction
    assign frac_ext = $signed({1'b0, frac5_reg});
    assign ip_full  = diff_reg * frac_ext;

    // Stage 7: round interpolation term half away from zero, add base point
    always_comb
    begin
        ip_abs = ip_reg[tcv_pkg::IP_W-1] ? (tcv_pkg::IP_W'(0) - ip_reg) : ip_reg;
        ip_sh  = (ip_abs + (tcv_pkg::IP_W'(1) << (tcv_pkg::FRAC_W - 1))) >> tcv_pkg::FRAC_W;
        interp = ip_reg[tcv_pkg::IP_W-1] ? -$signed({1'b0, ip_sh[15:0]})
                                         : $signed({1'b0, ip_sh[15:0]});
        tsum   = $signed({2'b00, lo6_reg}) + interp;
        tmag_next = sat6_reg ? tcv_pkg::TAB_W'(16384) : tsum[tcv_pkg::TAB_W-1:0];
    end

    // Stage 8: apply sign, subtract floor
    assign t_sgn  = neg7_reg ? -$signed({1'b0, tmag_reg}) : $signed({1'b0, tmag_reg});
    assign w_next = $signed({t_sgn[15], t_sgn}) - $signed({floor_reg[15], floor_reg});

    // Stage 9: gain multiply
    assign gain_ext = $signed({1'b0, gain_reg});
    assign p_full   = gain_ext * w_reg;

    // Stage 10: round to Q14 and clamp
    always_comb
    begin
        p_abs  = p_reg[40] ? (41'd0 - p_reg) : p_reg;
        q_full = (p_abs + (41'd1 << (tcv_pkg::OUT_SH - 1))) >> tcv_pkg::OUT_SH;
        q      = q_full[24:0];
        clip_next = 1'b0;
        if (!p_reg[40] && q > 25'd32767)
        begin
            y_next    = 16'sh7FFF;
            clip_next = 1'b1;
        end
        else if (p_reg[40] && q > 25'd32768)
        begin
            y_next    = 16'sh8000;
            clip_next = 1'b1;
        end
        else if (p_reg[40])
        begin
            y_next = 16'd0 - q[15:0];
        end
        else
        begin
            y_next = q[15:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg <= d_next;
        end
        if (en[1])
        begin
            u_reg <= u_full[32:0];
        end
        if (en[2])
        begin
            mag_reg  <= mag_abs[tcv_pkg::FRAC_W-1:0];
            sat3_reg <= |mag_abs[32:tcv_pkg::FRAC_W];
            neg3_reg <= u_reg[32];
        end
        if (en[3])
        begin
            idx_reg   <= s_full[tcv_pkg::S_W-1:tcv_pkg::FRAC_W];
            frac4_reg <= s_full[tcv_pkg::FRAC_W-1:0];
            sat4_reg  <= sat3_reg;
            neg4_reg  <= neg3_reg;
        end
        if (en[4])
        begin
            lo5_reg   <= lo_next;
            diff_reg  <= diff_next;
            frac5_reg <= frac4_reg;
            sat5_reg  <= sat4_reg;
            neg5_reg  <= neg4_reg;
        end
        if (en[5])
        begin
            lo6_reg  <= lo5_reg;
            ip_reg   <= ip_full[tcv_pkg::IP_W-1:0];
            sat6_reg <= sat5_reg;
            neg6_reg <= neg5_reg;
        end
        if (en[6])
        begin
            tmag_reg <= tmag_next;
            neg7_reg <= neg6_reg;
        end
        if (en[7])
        begin
            w_reg <= w_next;
        end
        if (en[8])
        begin
            p_reg <= p_full[40:0];
        end
        if (en[9])
        begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
    end

    // Result channel
    assign results.valid      = vld_reg[tcv_pkg::LAST];
    assign results.sample_out = y_reg;
    assign results.clipped    = clip_reg;

    // Checks
    `ASSERT_NEXT(a_accept_fills_first, samples.valid && samples.ready, vld_reg[0],
        "accepted request did not reach the first stage")
    `ASSERT_SAME(a_stall_only_when_full, !samples.ready,
        (&vld_reg) && !results.ready, "input stalled with room in the pipeline")
    `ASSERT_SAME(a_clip_at_rail, results.valid && results.clipped,
        results.sample_out == 16'sh7FFF || results.sample_out == 16'sh8000,
        "clip flag set on a value off the rails")

endmodule

// ----- test/tanh_transfer_curve_top_tb.sv -----
// Self-checking bench for tanh_transfer_curve_top: drives samples and register writes,
// predicts each shaped sample in a scoreboard class and compares every result.
// Depends on tcv_pkg, the three channel interfaces and the top level.
`timescale 1ns / 1ps

module tanh_transfer_curve_top_tb;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int HOLD_CYCLES     = 120;
    localparam int NUM_CORNERS     = 19;

    // One predicted result, with the sample that caused it
    typedef struct {
        logic signed [tcv_pkg::SAMPLE_W-1:0] x;
        logic signed [tcv_pkg::SAMPLE_W-1:0] y;
        logic                                clip;
    } shaped_t;

    // Scoreboard: own copy of the registers and tanh table, queue of due results
    class curve_board;
        bit [15:0]                  slope_q;
        logic signed [15:0]         centre_q;
        bit [23:0]                  gain_q;
        logic signed [15:0]         floor_q;
        longint                     tanh_lut [0:tcv_pkg::TABLE_ENTRIES];
        shaped_t                    shaped_due [$];
        int                         mismatches;
        int                         shaped_count;
        int                         clip_count;

        function new();
            bit [63:0] one_q30;
            bit [63:0] term;
            bit [63:0] sum;
            bit [63:0] e;
            bit [63:0] n;
            one_q30 = 64'd1 << 30;
            n       = 64'(tcv_pkg::TABLE_ENTRIES);
            // tanh(4i/N) via e^(i/N) Taylor series, reciprocal, three squarings
            for (int i = 0; i <= tcv_pkg::TABLE_ENTRIES; i++)
            begin
                term = one_q30;
                sum  = one_q30;
                for (int k = 1; k < 40 && term != 64'd0; k++)
                begin
                    term = term * 64'(i) / (n * 64'(k));
                    sum  = sum + term;
                end
                e = ((one_q30 << 30) + sum / 64'd2) / sum;
                for (int r = 0; r < 3; r++)
                begin
                    e = (e * e + (one_q30 >> 1)) >> 30;
                end
                tanh_lut[i] = longint'((((one_q30 - e) << 14) + (one_q30 + e) / 64'd2)
                                       / (one_q30 + e));
            end
            slope_q      = tcv_pkg::SLOPE_RST;
            centre_q     = tcv_pkg::CENTRE_RST;
            gain_q       = tcv_pkg::GAIN_RST;
            floor_q      = tcv_pkg::FLOOR_RST;
            mismatches   = 0;
            shaped_count = 0;
            clip_count   = 0;
        endfunction

        function void set_reg(bit [tcv_pkg::CFG_IDX_W-1:0] idx,
                              bit [tcv_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tcv_pkg::REG_SLOPE:  slope_q  = data[15:0];
                tcv_pkg::REG_CENTRE: centre_q = data[15:0];
                tcv_pkg::REG_GAIN:   gain_q   = data;
                tcv_pkg::REG_FLOOR:  floor_q  = data[15:0];
                default:             ;
            endcase
        endfunction

        // Round half away from zero
        function longint round_shift(longint v, int sh);
            longint half;
            half = longint'(1) <<< (sh - 1);
            if (v >= 0)
                return (v + half) >>> sh;
            return -((-v + half) >>> sh);
        endfunction

        function shaped_t shape_sample(logic signed [15:0] x);
            shaped_t res;
            longint  d;
            longint  u;
            longint  mag;
            longint  s;
            longint  f;
            longint  lo;
            longint  hi;
            longint  t;
            longint  y;
            int      idx;
            d   = longint'(x) - longint'(centre_q);
            u   = longint'(slope_q) * d;
            mag = (u < 0) ? -u : u;
            if (mag >= (longint'(1) <<< tcv_pkg::FRAC_W))
                t = 16384;
            else
            begin
                s   = mag * tcv_pkg::TABLE_ENTRIES;
                idx = int'(s >>> tcv_pkg::FRAC_W);
                f   = s & ((longint'(1) <<< tcv_pkg::FRAC_W) - 1);
                lo  = tanh_lut[idx];
                hi  = tanh_lut[idx + 1];
                t   = lo + round_shift((hi - lo) * f, tcv_pkg::FRAC_W);
            end
            if (u < 0)
                t = -t;
            y = round_shift(longint'(gain_q) * (t - longint'(floor_q)), tcv_pkg::OUT_SH);
            res.x    = x;
            res.clip = 1'b0;
            if (y > 32767)
            begin
                y        = 32767;
                res.clip = 1'b1;
            end
            if (y < -32768)
            begin
                y        = -32768;
                res.clip = 1'b1;
            end
            res.y = 16'(y);
            return res;
        endfunction

        function void note_sample(logic signed [15:0] x);
            shaped_due.push_back(shape_sample(x));
        endfunction

        function void check_result(logic signed [15:0] y, logic clip);
            shaped_t exp_r;
            if (shaped_due.size() == 0)
            begin
                $error("unexpected result: sample_out %0d, clipped %0b", y, clip);
                mismatches++;
                return;
            end
            exp_r = shaped_due.pop_front();
            shaped_count++;
            if (clip)
                clip_count++;
            if (y !== exp_r.y)
            begin
                $error("sample_out (x=%0d): expected %0d, actual %0d", exp_r.x, exp_r.y, y);
                mismatches++;
            end
            if (clip !== exp_r.clip)
            begin
                $error("clipped (x=%0d): expected %0b, actual %0b", exp_r.x, exp_r.clip, clip);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return shaped_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tcv_sample_if sample_ch ();
    tcv_result_if result_ch ();
    tcv_cfg_if    cfg_ch ();

    tanh_transfer_curve_top u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    curve_board board;
    bit         tx_calm;
    bit         rx_calm;
    bit         squeeze_req;

    // Edge points of the curve at reset settings: ends, centre, |u| = 4 boundary
    logic signed [15:0] corner_x [NUM_CORNERS] = '{
        -16'sd32768, 16'sd32767, 16'sd0, 16'sd16384, 16'sd8192, 16'sd8191, 16'sd8193,
        -16'sd1, 16'sd1, 16'sd25028, 16'sd25029, -16'sd8644, -16'sd8645, 16'sd4096,
        16'sd12288, 16'sh5555, 16'shAAAA, 16'sd8196, 16'sd8188
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #2000000;
        $display("tanh_transfer_curve_top_tb failed");
        $finish;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Real-valued register derivation as software does it, rounded and clamped
    function automatic longint to_fixed(real v, real scale, longint lo, longint hi);
        real    r;
        longint q;
        r = v * scale;
        q = $rtoi(r + ((r >= 0.0) ? 0.5 : -0.5));
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q;
    endfunction

    task automatic derive_curve(input real offset, input real width,
                                output bit [15:0] s, output bit [15:0] c,
                                output bit [23:0] g, output bit [15:0] f);
        real a;
        real b;
        real beta;
        real alpha;
        a     = (width <= 0.0) ? $ln(7.0) : $ln(7.0) / width;
        b     = (offset + 1.0) / 2.0;
        beta  = $tanh(-a * b);
        alpha = 1.0 / ($tanh(a * (1.0 - b)) - beta);
        s     = 16'(to_fixed(a, 1024.0, 0, 65535));
        c     = 16'(to_fixed(b, 16384.0, -32768, 32767));
        g     = 24'(to_fixed(alpha, 65536.0, 0, 16777215));
        f     = 16'(to_fixed(beta, 16384.0, -16384, 16384));
    endtask

    // Write all four registers back to back; unused upper data bits are random
    task automatic apply_setting(input bit [15:0] s, input bit [15:0] c,
                                 input bit [23:0] g, input bit [15:0] f);
        bit [tcv_pkg::CFG_IDX_W-1:0]  idx;
        bit [tcv_pkg::CFG_DATA_W-1:0] data;
        for (int r = 0; r < 4; r++)
        begin
            idx = tcv_pkg::CFG_IDX_W'(r);
            case (idx)
                tcv_pkg::REG_SLOPE:  data = {8'($urandom), s};
                tcv_pkg::REG_CENTRE: data = {8'($urandom), c};
                tcv_pkg::REG_GAIN:   data = g;
                default:             data = {8'($urandom), f};
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= data;
            do @(posedge clk); while (!cfg_ch.ready);
            board.set_reg(idx, data);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one sample and hold it until the request is taken
    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= x;
        do @(posedge clk); while (!sample_ch.ready);
        board.note_sample(x);
    endtask

    // Random sample: full range, near the centre (inside the table), or an extreme
    function automatic logic signed [15:0] pick_sample();
        longint spread;
        longint off;
        case ($urandom_range(0, 3)) inside
            [0:1]:   return 16'($urandom);
            2:
            begin
                spread = (board.slope_q == 0) ? 32767
                         : (longint'(1) <<< tcv_pkg::FRAC_W) / longint'(board.slope_q);
                if (spread > 32767)
                    spread = 32767;
                off = longint'($urandom_range(0, 32'(2 * spread))) - spread;
                return 16'(longint'(board.centre_q) + off);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return 16'sd0;
                    default: return 16'sd16384;
                endcase
            end
        endcase
    endfunction

    task automatic drain();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result side: check accepted results, idle at random, long hold on request
    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                board.check_result(result_ch.sample_out, result_ch.clipped);
            if (stall_left > 0)
                stall_left--;
            else if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                stall_left  = HOLD_CYCLES;
            end
            else if (!rx_calm)
                stall_left = pick_gap();
            result_ch.ready <= (stall_left == 0);
        end
    end

    // Main sequence
    initial
    begin
        bit [15:0] s;
        bit [15:0] c;
        bit [23:0] g;
        bit [15:0] f;
        board               = new();
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        squeeze_req         = 1'b0;
        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = tcv_pkg::REG_SLOPE;
        cfg_ch.data         = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // New register setting once the pipeline is empty
            if (p > 0)
            begin
                drain();
                case (p)
                    1:       derive_curve(-0.2, 0.3, s, c, g, f);
                    2:       {s, c, g, f} = {16'hFFFF, 16'h0000, 24'h010000, 16'h0000};
                    3:       {s, c, g, f} = {16'h0000, 16'h8000, 24'hFFFFFF, 16'h8000};
                    4:       {s, c, g, f} = {16'h0001, 16'h7FFF, 24'h000000, 16'h7FFF};
                    5:       derive_curve(0.6, -1.0, s, c, g, f);
                    6:       {s, c, g, f} = {16'd2000, 16'h0000, 24'h020000, 16'h4000};
                    7:       derive_curve(($urandom_range(0, 2000) - 1000.0) / 1000.0,
                                          $urandom_range(50, 2000) / 1000.0, s, c, g, f);
                    default:
                    begin
                        s = 16'($urandom);
                        c = 16'($urandom);
                        g = ($urandom_range(0, 1) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 24'h03FFFF));
                        f = 16'($urandom);
                    end
                endcase
                apply_setting(s, c, g, f);
            end

            // Phase 1 keeps offering while the result side holds off
            tx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
            rx_calm = (p != 1) && ($urandom_range(0, 3) == 0);
            if (p == 1)
                squeeze_req = 1'b1;

            if (p == 0)
            begin
                for (int i = 0; i < NUM_CORNERS; i++)
                    send_sample(corner_x[i]);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_sample(pick_sample());
            sample_ch.valid <= 1'b0;
        end

        drain();
        repeat (2 * tcv_pkg::NSTG) @(posedge clk);
        $display("Checked %0d shaped samples (%0d clipped) over %0d register settings,",
                 board.shaped_count, board.clip_count, NUM_PHASES);
        $display("including register extremes and a long result-side hold.");
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("tanh_transfer_curve_top_tb passed");
        else
            $display("tanh_transfer_curve_top_tb failed");
        $finish;
    end

endmodule
